// File: hw/rtl/tulw_pkg.sv
`default_nettype none

package tulw_pkg;

   localparam logic [7:0] RS_MASK        = 8'd1;
   localparam logic [7:0] EN_MASK        = 8'd4;
   localparam logic [7:0] BACKLIGHT_MASK = 8'd8;

   localparam logic [7:0] CH_LATIN1_LEAD = 8'd195;
   localparam logic [7:0] CH_LEAD_C4     = 8'd196;
   localparam logic [7:0] CH_LEAD_C5     = 8'd197;
   localparam logic [7:0] CH_O_UML_LO    = 8'd182;
   localparam logic [7:0] CH_O_UML_UP    = 8'd150;
   localparam logic [7:0] CH_U_UML_UP    = 8'd156;
   localparam logic [7:0] CH_U_UML_LO    = 8'd188;
   localparam logic [7:0] CH_C_CED_UP    = 8'd135;
   localparam logic [7:0] CH_C_CED_LO    = 8'd167;
   localparam logic [7:0] CH_CONT_9E     = 8'd158;
   localparam logic [7:0] CH_CONT_9F     = 8'd159;
   localparam logic [7:0] CH_CONT_B0     = 8'd176;
   localparam logic [7:0] CH_CONT_B1     = 8'd177;

   localparam logic [7:0] ROM_O_UML      = 8'd239;
   localparam logic [7:0] ROM_U_UML      = 8'd245;
   localparam logic [7:0] GLYPH_C_CED    = 8'd0;
   localparam logic [7:0] GLYPH_G_UP     = 8'd1;
   localparam logic [7:0] GLYPH_S_CED    = 8'd2;
   localparam logic [7:0] GLYPH_G_LO     = 8'd3;
   localparam logic [7:0] GLYPH_I_DOT    = 8'd4;
   localparam logic [7:0] GLYPH_I_DOTLESS = 8'd5;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_BACKLIGHT = 3'd0;

   typedef struct packed {
      logic       send;
      logic [7:0] code;
      logic       rs;
   } tulw_map_type;

   typedef enum logic [2:0] {
      PH_PLAIN   = 3'b001,
      PH_STROBE  = 3'b010,
      PH_RELEASE = 3'b100
   } tulw_phase_type;

endpackage

`default_nettype wire

// File: hw/rtl/tulw_if.sv
`default_nettype none

interface tulw_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink (input valid, input action, input value, output ready);
endinterface

interface tulw_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] expander_byte;
   logic       last;

   modport source (output valid, output expander_byte, output last, input ready);
   modport sink (input valid, input expander_byte, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/turkish_utf8_lcd_nibble_writer.sv
`default_nettype none

// Turkish UTF-8 character writer for a character LCD on a 4-bit port-expander
// bus. Each request beat is a character (action 0, mapped through the Turkish
// lead/continuation rules) or a raw command (action 1). A byte that is sent
// leaves as six response beats, one per cycle while rsp is ready: high nibble
// plain, strobed, released, then the same for the low nibble; the sixth beat
// has last set. Lead bytes and dropped bytes produce no beats. The nibble
// sequencer takes the next request in the cycle of the last beat, so writes
// stream without gaps. The backlight register (addresses 0 to 3, as only the
// top address bit is decoded) is applied to beats as they leave.

module turkish_utf8_lcd_nibble_writer
   import tulw_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   tulw_req_if.sink                   req_ch,
   tulw_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic         backlight_ff;
   logic         can_load;
   logic         accept;
   tulw_map_type map;

   assign csr_pready   = 1'b1;
   assign req_ch.ready = can_load;
   assign accept       = req_ch.valid & can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         backlight_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[CSR_ADDR_W-1] == CSR_BACKLIGHT[CSR_ADDR_W-1]) begin
         backlight_ff <= csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[CSR_ADDR_W-1] == CSR_BACKLIGHT[CSR_ADDR_W-1]) begin
         csr_prdata = {31'd0, backlight_ff};
      end
   end

   tulw_mapper u_mapper (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .action (req_ch.action),
      .value  (req_ch.value),
      .map    (map)
   );

   tulw_nibble_ser u_ser (
      .clock     (clock),
      .reset     (reset),
      .load      (accept & map.send),
      .code      (map.code),
      .rs        (map.rs),
      .backlight (backlight_ff),
      .can_load  (can_load),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

// File: hw/rtl/tulw_mapper.sv
`default_nettype none

module tulw_mapper
   import tulw_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         accept,
   input  wire logic         action,
   input  wire logic [7:0]   value,
   output tulw_map_type      map
);

   logic c4_ff, c4_in;
   logic c5_ff, c5_in;

   always_comb begin
      map.send = 1'b1;
      map.code = value;
      map.rs   = ~action;
      c4_in    = c4_ff;
      c5_in    = c5_ff;
      if (!action) begin
         case (value)
            CH_LATIN1_LEAD: begin
               map.send = 1'b0;
            end
            CH_LEAD_C4: begin
               map.send = 1'b0;
               c4_in    = 1'b1;
            end
            CH_LEAD_C5: begin
               map.send = 1'b0;
               c5_in    = 1'b1;
            end
            CH_O_UML_LO, CH_O_UML_UP: begin
               map.code = ROM_O_UML;
            end
            CH_U_UML_UP, CH_U_UML_LO: begin
               map.code = ROM_U_UML;
            end
            CH_C_CED_UP, CH_C_CED_LO: begin
               map.code = GLYPH_C_CED;
            end
            CH_CONT_9E, CH_CONT_9F: begin
               if (c4_ff) begin
                  map.code = (value == CH_CONT_9E) ? GLYPH_G_UP : GLYPH_G_LO;
                  c4_in    = 1'b0;
               end else if (c5_ff) begin
                  map.code = GLYPH_S_CED;
                  c5_in    = 1'b0;
               end else begin
                  map.send = 1'b0;
               end
            end
            CH_CONT_B0, CH_CONT_B1: begin
               if (c4_ff) begin
                  map.code = (value == CH_CONT_B0) ? GLYPH_I_DOT : GLYPH_I_DOTLESS;
                  c4_in    = 1'b0;
               end else begin
                  map.send = 1'b0;
               end
            end
            default: begin
               map.code = value;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c4_ff <= 1'b0;
         c5_ff <= 1'b0;
      end else if (accept) begin
         c4_ff <= c4_in;
         c5_ff <= c5_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/tulw_nibble_ser.sv
`default_nettype none

module tulw_nibble_ser
   import tulw_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load,
   input  wire logic [7:0] code,
   input  wire logic      rs,
   input  wire logic      backlight,
   output logic           can_load,
   tulw_rsp_if.source     rsp_ch
);

   logic           busy_ff;
   logic           low_ff;
   tulw_phase_type phase_ff;
   logic [7:0]     code_ff;
   logic           rs_ff;

   logic [3:0] nib;
   logic [7:0] base;
   logic [7:0] beat;
   logic       take;
   logic       last_beat;

   assign take      = rsp_ch.valid & rsp_ch.ready;
   assign last_beat = low_ff & (phase_ff == PH_RELEASE);
   assign can_load  = ~busy_ff | (take & last_beat);

   assign nib  = low_ff ? code_ff[3:0] : code_ff[7:4];
   assign base = {nib, 4'b0000} | (rs_ff ? RS_MASK : 8'd0);

   always_comb begin
      case (phase_ff)
         PH_PLAIN:   beat = base;
         PH_STROBE:  beat = base | EN_MASK;
         PH_RELEASE: beat = base & ~EN_MASK;
         default:    beat = base;
      endcase
   end

   assign rsp_ch.valid         = busy_ff;
   assign rsp_ch.expander_byte = beat | (backlight ? BACKLIGHT_MASK : 8'd0);
   assign rsp_ch.last          = last_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         low_ff   <= 1'b0;
         phase_ff <= PH_PLAIN;
      end else if (load) begin
         busy_ff  <= 1'b1;
         low_ff   <= 1'b0;
         phase_ff <= PH_PLAIN;
      end else if (take) begin
         case (phase_ff)
            PH_PLAIN:   phase_ff <= PH_STROBE;
            PH_STROBE:  phase_ff <= PH_RELEASE;
            PH_RELEASE: begin
               phase_ff <= PH_PLAIN;
               low_ff   <= 1'b1;
               if (low_ff) begin
                  busy_ff <= 1'b0;
               end
            end
            default:    phase_ff <= PH_PLAIN;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= code;
         rs_ff   <= rs;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/tulw_checker.sv
`default_nettype none

module tulw_checker
   import tulw_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_expander_byte,
   input wire logic       rsp_last,
   input wire logic       csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_expander_byte)
                                  && $stable(rsp_last))
      else $error("response beat changed while stalled");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("request not taken while no write is in flight");

   a_write_unbroken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("write ended before its last beat");

   a_last_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> (rsp_expander_byte & EN_MASK & ~BACKLIGHT_MASK) == 8'd0)
      else $error("last beat has enable set");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready dropped");

endmodule

bind turkish_utf8_lcd_nibble_writer tulw_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_expander_byte (rsp_ch.expander_byte),
   .rsp_last          (rsp_ch.last),
   .csr_pready        (csr_pready)
);

`default_nettype wire
